/* hw/rtl/box_blur_3x3_edge_aware_unit_assert.svh */
// Assertion macros shared by the box blur RTL.
`ifndef BOX_BLUR_3X3_EDGE_AWARE_UNIT_ASSERT_SVH
`define BOX_BLUR_3X3_EDGE_AWARE_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BB3_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BB3_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/bb3_pkg.sv */
// Types and constants for the 3x3 box blur unit.
package bb3_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int DIM_W      = 11;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int CH_W       = 8;
  localparam int PIX_W      = 3 * CH_W;
  localparam int CSUM_W     = CH_W + 2;
  localparam int TSUM_W     = CH_W + 4;
  localparam int DIVD_W     = TSUM_W + 1;
  localparam int N_W        = 4;
  localparam int DS_W       = N_W + CH_W;
  localparam int STEP_W     = $clog2(CH_W);
  localparam int CFG_IDX_W  = 1;

  localparam logic REQ_DRAIN = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pix_t;

  // index 0 = top row of the window
  typedef pix_t [2:0] col_t;

  // channel order in sum and quotient vectors: 2 red, 1 green, 0 blue
  typedef logic [2:0][CSUM_W-1:0] csum_t;
  typedef logic [2:0][TSUM_W-1:0] tsum_t;
  typedef logic [2:0][CH_W-1:0]   qout_t;

  typedef struct packed {
    logic       shift;
    logic [2:0] row_en;
  } cell_ctrl_t;

  typedef struct packed {
    logic            req_type;
    logic [CH_W-1:0] in_red;
    logic [CH_W-1:0] in_green;
    logic [CH_W-1:0] in_blue;
  } in_word_t;

  typedef struct packed {
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
    logic            frame_done;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_LOAD,
    ST_SUM,
    ST_DIV,
    ST_OUT
  } bb3_state_t;

  typedef enum logic {
    NB_WIN,
    NB_EDGE
  } nb_mode_t;

endpackage

/* hw/rtl/bb3_cell.sv */
// One window column cell: holds three pixels, shifts to its neighbour, sums masked rows.
module bb3_cell (
  input  logic               clk,
  input  bb3_pkg::cell_ctrl_t ctrl,
  input  bb3_pkg::col_t      col_in,
  output bb3_pkg::col_t      col_out,
  output bb3_pkg::csum_t     col_sum
);
  import bb3_pkg::*;

  col_t col_r;

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      col_r <= col_in;
    end
  end

  assign col_out = col_r;

  always_comb begin
    col_sum = '0;
    for (int r = 0; r < 3; r++) begin
      if (ctrl.row_en[r]) begin
        col_sum[2] = col_sum[2] + CSUM_W'(col_r[r].red);
        col_sum[1] = col_sum[1] + CSUM_W'(col_r[r].green);
        col_sum[0] = col_sum[0] + CSUM_W'(col_r[r].blue);
      end
    end
  end

endmodule

/* hw/rtl/bb3_div.sv */
// Bit-serial rounding divider, three channels side by side: (2*sum+n)/(2*n).
module bb3_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  bb3_pkg::tsum_t            sum,
  input  logic [bb3_pkg::N_W-1:0]   n,
  output logic                      busy,
  output logic                      done,
  output bb3_pkg::qout_t            quot
);
  import bb3_pkg::*;

  logic [2:0][DIVD_W-1:0] rem_r;
  logic [DS_W-1:0]        ds_r;
  logic [STEP_W-1:0]      cnt_r;
  logic                   busy_r;
  logic                   done_r;
  qout_t                  quot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= STEP_W'(CH_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // divisor 2n starts aligned to the top quotient bit
  always_ff @(posedge clk) begin
    if (start) begin
      ds_r <= {n, {CH_W{1'b0}}};
      for (int c = 0; c < 3; c++) begin
        rem_r[c] <= {sum[c], 1'b0} + DIVD_W'(n);
      end
    end else if (busy_r) begin
      ds_r <= ds_r >> 1;
      for (int c = 0; c < 3; c++) begin
        if (rem_r[c] >= DIVD_W'(ds_r)) begin
          rem_r[c]  <= rem_r[c] - DIVD_W'(ds_r);
          quot_r[c] <= {quot_r[c][CH_W-2:0], 1'b1};
        end else begin
          quot_r[c] <= {quot_r[c][CH_W-2:0], 1'b0};
        end
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = quot_r;

endmodule

/* hw/rtl/box_blur_3x3_edge_aware_unit.sv */
// A pixel reads its line-store column and is stored; if it closes a window it is then summed,
// divided and output. An edge word (pixel opening a row from the third on, or drain above the
// last row) is summed, divided and output first; an edge pixel is then stored. Drain in the
// last row reads 3 line-store columns, then divides. New words are taken only while idle.
// Reset (rst_n low, synchronous): 1024 x 1024 frame, counters zero, no pending output.
// Line store contents are not cleared; rows not yet written this frame are read only into masked rows.
module box_blur_3x3_edge_aware_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  bb3_pkg::in_word_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output bb3_pkg::out_word_t            out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bb3_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bb3_pkg::DIM_W-1:0]     cfg_data
);
  import bb3_pkg::*;

`include "box_blur_3x3_edge_aware_unit_assert.svh"

  // clamp a size register to 1..limit
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] lim);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > lim) begin
      r = lim;
    end
    return r;
  endfunction

  localparam logic [DIM_W-1:0] WIDTH_LIM  = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] HEIGHT_LIM = DIM_W'(MAX_HEIGHT);
  localparam logic [1:0]       LD_LAST    = 2'd2;

  // control state
  bb3_state_t         state_r, state_nxt;
  logic [DIM_W-1:0]   width_r, height_r;
  logic [COL_W-1:0]   in_col_r;
  logic [DIM_W-1:0]   in_row_r;
  logic [COL_W-1:0]   out_col_r;
  logic [ROW_W-1:0]   out_row_r;
  nb_mode_t           mode_r;
  logic               pix_pend_r;     // edge word emitted first, pixel still to store
  logic               stores_r;       // drain in last row, window refilled from line store
  logic [1:0]         ld_cnt_r;
  logic               out_valid_r;

  // payload
  pix_t               pix_r;
  logic [2*PIX_W-1:0] rd_data_r;
  out_word_t          out_data_r;

  // line store: {older row, newer row} per column
  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];

  // handshake and decode
  logic               in_fire;
  logic               is_drain;
  logic               drain_ok;
  logic               pix_ok;
  logic               pix_edge;
  logic               last_row;
  logic               emit_pix;
  logic               shift;
  logic               div_start;
  logic               out_load;
  logic [COL_W-1:0]   rd_addr;

  // neighbourhood masks
  logic [2:0]         row_en;
  logic               cm0, cm2;
  logic [1:0]         rcnt, ccnt;
  logic [N_W-1:0]     n_cnt;
  logic               last_pix;

  // window chain
  cell_ctrl_t         cctrl;
  col_t               new_col;
  col_t               c2_out, c1_out, c0_out;
  csum_t              s0, s1, s2;
  tsum_t              total;

  logic               div_busy;
  logic               div_done;
  qout_t              quot;
  out_word_t          out_data_nxt;
  pix_t               rd_older, rd_newer;

  assign in_fire  = in_valid && in_ready;
  assign is_drain = (in_data.req_type == REQ_DRAIN);
  assign drain_ok = (in_row_r >= height_r) && (DIM_W'(out_row_r) < height_r);
  assign pix_ok   = (in_row_r < height_r);
  assign pix_edge = (in_col_r == '0) && (in_row_r >= DIM_W'(2));
  assign emit_pix = (in_col_r != '0) && (in_row_r != '0);

  // masks follow the output position
  assign row_en[0] = (out_row_r != '0);
  assign row_en[1] = 1'b1;
  assign row_en[2] = (DIM_W'(out_row_r) + DIM_W'(1)) < height_r;
  assign cm0       = (out_col_r != '0);
  assign cm2       = (DIM_W'(out_col_r) + DIM_W'(1)) < width_r;
  assign last_row  = !row_en[2];
  assign last_pix  = !row_en[2] && !cm2;
  assign rcnt      = 2'd1 + 2'(row_en[0]) + 2'(row_en[2]);
  assign ccnt      = 2'd1 + 2'(cm0) + 2'(cm2);
  assign n_cnt     = N_W'(rcnt) * N_W'(ccnt);

  assign rd_addr = stores_r ? (out_col_r + COL_W'(ld_cnt_r) - COL_W'(1)) : in_col_r;
  assign rd_older = rd_data_r[2*PIX_W-1:PIX_W];
  assign rd_newer = rd_data_r[PIX_W-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (is_drain) begin
            if (drain_ok) begin
              state_nxt = last_row ? ST_RD : ST_SUM;
            end
          end else if (pix_ok) begin
            state_nxt = pix_edge ? ST_SUM : ST_RD;
          end
        end
      end
      ST_RD: state_nxt = ST_LOAD;
      ST_LOAD: begin
        if (stores_r) begin
          state_nxt = (ld_cnt_r == LD_LAST) ? ST_SUM : ST_RD;
        end else begin
          state_nxt = emit_pix ? ST_SUM : ST_IDLE;
        end
      end
      ST_SUM: state_nxt = ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = pix_pend_r ? ST_RD : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready  = 1'b0;
    shift     = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: in_ready  = 1'b1;
      ST_RD:   ;
      ST_LOAD: shift     = 1'b1;
      ST_SUM:  div_start = 1'b1;
      ST_DIV:  ;
      ST_OUT:  out_load  = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  assign cfg_ready = 1'b1;

  // window chain: new column enters cell 2 and moves towards cell 0
  assign cctrl.shift  = shift;
  assign cctrl.row_en = row_en;

  always_comb begin
    new_col[0] = rd_older;
    new_col[1] = rd_newer;
    new_col[2] = stores_r ? '0 : pix_r;
  end

  bb3_cell u_cell2 (.clk(clk), .ctrl(cctrl), .col_in(new_col), .col_out(c2_out), .col_sum(s2));
  bb3_cell u_cell1 (.clk(clk), .ctrl(cctrl), .col_in(c2_out), .col_out(c1_out), .col_sum(s1));
  bb3_cell u_cell0 (.clk(clk), .ctrl(cctrl), .col_in(c1_out), .col_out(c0_out), .col_sum(s0));

  // c0_out leaves the chain; nothing further down
  logic unused_tail;
  assign unused_tail = ^c0_out;

  // window sum; right-edge case: centre in cell 2, right neighbour column is outside
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (mode_r == NB_EDGE) begin
        total[c] = (cm0 ? TSUM_W'(s1[c]) : '0) + TSUM_W'(s2[c]);
      end else begin
        total[c] = (cm0 ? TSUM_W'(s0[c]) : '0) + TSUM_W'(s1[c])
                 + (cm2 ? TSUM_W'(s2[c]) : '0);
      end
    end
  end

  bb3_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .sum   (total),
    .n     (n_cnt),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (quot)
  );

  assign out_data_nxt.out_red    = quot[2];
  assign out_data_nxt.out_green  = quot[1];
  assign out_data_nxt.out_blue   = quot[0];
  assign out_data_nxt.frame_done = last_pix;

  // line store
  always_ff @(posedge clk) begin
    if (state_r == ST_RD) begin
      rd_data_r <= line_mem[rd_addr];
    end
    if (state_r == ST_LOAD && !stores_r) begin
      line_mem[in_col_r] <= {rd_newer, pix_r};
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      width_r     <= WIDTH_LIM;
      height_r    <= HEIGHT_LIM;
      in_col_r    <= '0;
      in_row_r    <= '0;
      out_col_r   <= '0;
      out_row_r   <= '0;
      mode_r      <= NB_WIN;
      pix_pend_r  <= 1'b0;
      stores_r    <= 1'b0;
      ld_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_FRAME_WIDTH:  width_r  <= clamp_dim(cfg_data, WIDTH_LIM);
          CFG_FRAME_HEIGHT: height_r <= clamp_dim(cfg_data, HEIGHT_LIM);
          default: ;
        endcase
        in_col_r  <= '0;
        in_row_r  <= '0;
        out_col_r <= '0;
        out_row_r <= '0;
      end

      if (in_fire) begin
        pix_pend_r <= !is_drain && pix_edge;
        stores_r   <= is_drain && last_row;
        ld_cnt_r   <= '0;
        mode_r     <= ((is_drain && !last_row) || (!is_drain && pix_edge)) ? NB_EDGE : NB_WIN;
      end

      if (state_r == ST_LOAD) begin
        if (stores_r) begin
          ld_cnt_r <= ld_cnt_r + 2'd1;
        end else if ((DIM_W'(in_col_r) + DIM_W'(1)) >= width_r) begin
          in_col_r <= '0;
          in_row_r <= in_row_r + DIM_W'(1);
        end else begin
          in_col_r <= in_col_r + COL_W'(1);
        end
      end

      if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
        pix_pend_r  <= 1'b0;
        stores_r    <= 1'b0;
        mode_r      <= NB_WIN;
        if (last_pix) begin
          in_col_r  <= '0;
          in_row_r  <= '0;
          out_col_r <= '0;
          out_row_r <= '0;
        end else if (!cm2) begin
          out_col_r <= '0;
          out_row_r <= out_row_r + ROW_W'(1);
        end else begin
          out_col_r <= out_col_r + COL_W'(1);
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      pix_r.red   <= in_data.in_red;
      pix_r.green <= in_data.in_green;
      pix_r.blue  <= in_data.in_blue;
    end
    if (out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `BB3_ASSERT_NOW(a_idle_div_quiet, in_ready, !div_busy, "divider busy while accepting")
  `BB3_ASSERT_NOW(a_div_done_state, div_done, state_r == ST_DIV, "divider result outside DIV")
  `BB3_ASSERT_NXT(a_frame_restart, out_load && last_pix,
                  in_row_r == '0 && out_row_r == '0 && out_col_r == '0,
                  "counters not cleared after last word of frame")
  `BB3_ASSERT_NOW(a_out_row_range, 1'b1, DIM_W'(out_row_r) < height_r,
                  "output row beyond frame height")

endmodule

/* tb/box_blur_3x3_edge_aware_unit_tb.sv */
// Self-checking testbench for the 3x3 edge-aware box blur unit.
`timescale 1ns / 100ps

module box_blur_3x3_edge_aware_unit_tb;
  import bb3_pkg::*;

  localparam logic REQ_PIXEL = ~REQ_DRAIN;
  localparam int   SETTLE    = 40;         // wait, in cycles, for the pipe to settle
  localparam int   LIMIT     = 3_000_000;  // cycles
  localparam int   N_WORDS   = 2000;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  in_word_t  in_data;
  out_word_t out_data;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIM_W-1:0]     cfg_data;

  box_blur_3x3_edge_aware_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------
  // Blur predictor: own copy of line stores, window and counters
  // ---------------------------------------------------------------
  pix_t    line_old [MAX_WIDTH];
  pix_t    line_new [MAX_WIDTH];
  pix_t    win [9];               // row-major, column 2 is the newest
  int      fw, fh;                // clamped frame size
  int      wr_row, wr_col;        // next pixel to arrive
  int      px_row, px_col;        // next blurred pixel to leave

  out_word_t blur_q [$];          // blurred words still owed by the DUT

  function automatic int clamp_dim(logic [DIM_W-1:0] v, int hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return int'(v);
  endfunction

  function automatic void restart_counters();
    wr_row = 0; wr_col = 0; px_row = 0; px_col = 0;
  endfunction

  function automatic void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] v);
    if (idx == CFG_FRAME_WIDTH) fw = clamp_dim(v, MAX_WIDTH);
    else                        fh = clamp_dim(v, MAX_HEIGHT);
    restart_counters();
  endfunction

  // mean over the in-frame part of nb, centred at (px_row, px_col); steps counters
  function automatic out_word_t blur_at(pix_t nb [9]);
    int sr, sg, sb, n;
    out_word_t o;
    sr = 0; sg = 0; sb = 0; n = 0;
    for (int i = 0; i < 3; i++) begin
      if (i == 0 && px_row == 0) continue;
      if (i == 2 && px_row + 1 >= fh) continue;
      for (int j = 0; j < 3; j++) begin
        if (j == 0 && px_col == 0) continue;
        if (j == 2 && px_col + 1 >= fw) continue;
        sr += nb[i*3+j].red; sg += nb[i*3+j].green; sb += nb[i*3+j].blue;
        n++;
      end
    end
    o.out_red   = CH_W'((2*sr + n) / (2*n));
    o.out_green = CH_W'((2*sg + n) / (2*n));
    o.out_blue  = CH_W'((2*sb + n) / (2*n));
    if (px_row + 1 >= fh && px_col + 1 >= fw) begin
      o.frame_done = 1'b1;
      restart_counters();
    end else begin
      o.frame_done = 1'b0;
      px_col++;
      if (px_col >= fw) begin
        px_col = 0; px_row++;
      end
    end
    return o;
  endfunction

  // right-hand column of the window is the centre's right edge: pad with zero
  function automatic out_word_t blur_right_edge();
    pix_t nb [9];
    for (int i = 0; i < 3; i++) begin
      nb[i*3]   = win[i*3+1];
      nb[i*3+1] = win[i*3+2];
      nb[i*3+2] = '0;
    end
    return blur_at(nb);
  endfunction

  // last row: neighbours read straight from the line stores
  function automatic out_word_t blur_last_row();
    pix_t nb [9];
    int c;
    for (int k = 0; k < 9; k++) nb[k] = '0;
    for (int j = 0; j < 3; j++) begin
      c = px_col + j;
      if (c >= 1 && c - 1 < fw) begin
        nb[j]   = line_old[c-1];
        nb[3+j] = line_new[c-1];
      end
    end
    return blur_at(nb);
  endfunction

  // returns 1 when the word yields a blurred pixel
  function automatic bit predict_blur(in_word_t w, output out_word_t o);
    pix_t p, col [3];
    bit   got;
    got = 1'b0;
    o   = '0;
    if (w.req_type == REQ_DRAIN) begin
      if (wr_row < fh || px_row >= fh) return 1'b0;
      if (px_row + 1 >= fh) o = blur_last_row();
      else                  o = blur_right_edge();
      return 1'b1;
    end
    if (wr_row >= fh) return 1'b0;   // frame already complete
    p = '{w.in_red, w.in_green, w.in_blue};
    if (wr_col == 0 && wr_row >= 2) begin
      o = blur_right_edge(); got = 1'b1;
    end
    col[0] = line_old[wr_col];
    col[1] = line_new[wr_col];
    col[2] = p;
    line_old[wr_col] = col[1];
    line_new[wr_col] = p;
    for (int i = 0; i < 3; i++) begin
      win[i*3]   = win[i*3+1];
      win[i*3+1] = win[i*3+2];
      win[i*3+2] = col[i];
    end
    if (wr_col >= 1 && wr_row >= 1) begin
      o = blur_at(win); got = 1'b1;
    end
    wr_col++;
    if (wr_col >= fw) begin
      wr_col = 0; wr_row++;
    end
    return got;
  endfunction

  // ---------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------
  int        n_fail, n_blurred, n_frames_done, n_words, n_drains, n_cfg;
  int        cycle_cnt;
  bit        row_typed;        // word on the bus has a hand-written expectation
  out_word_t row_expect;

  task automatic report_mismatch(string what);
    $display("[%0t] MISMATCH: %s", $realtime, what);
    n_fail++;
  endtask

  always @(posedge clk) begin
    out_word_t e, pred;
    bit        got;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (blur_q.size() == 0) begin
          report_mismatch($sformatf("unexpected word %h", out_data));
        end else begin
          e = blur_q.pop_front();
          if (out_data.out_red != e.out_red)
            report_mismatch($sformatf("red %0d, want %0d", out_data.out_red, e.out_red));
          if (out_data.out_green != e.out_green)
            report_mismatch($sformatf("green %0d, want %0d",
                                      out_data.out_green, e.out_green));
          if (out_data.out_blue != e.out_blue)
            report_mismatch($sformatf("blue %0d, want %0d", out_data.out_blue, e.out_blue));
          if (out_data.frame_done != e.frame_done)
            report_mismatch($sformatf("frame_done %0b, want %0b",
                                      out_data.frame_done, e.frame_done));
          n_blurred++;
          if (e.frame_done) n_frames_done++;
        end
      end
      if (in_valid && in_ready) begin
        got = predict_blur(in_data, pred);
        n_words++;
        if (in_data.req_type == REQ_DRAIN) n_drains++;
        if (row_typed) begin
          if (!got) report_mismatch("predictor gave nothing for a typed row");
          blur_q.push_back(row_expect);
        end else if (got) begin
          blur_q.push_back(pred);
        end
      end
      if (cfg_valid && cfg_ready) begin
        set_reg(cfg_index, cfg_data);
        n_cfg++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------
  // Idling: mostly short gaps, a few long, bursts with none
  // ---------------------------------------------------------------
  bit no_idle;

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  int stall_left;
  initial begin
    out_ready  = 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        out_ready  <= 1'b0;
        stall_left--;
      end else begin
        out_ready  <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------
  task automatic send_word(in_word_t w, bit typed, out_word_t exp_w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_data    <= w;
    row_typed  <= typed;
    row_expect <= exp_w;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  // only between frames: wait for every owed word, then let the pipe settle
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (blur_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic in_word_t pixel_word();
    in_word_t w;
    w.req_type = REQ_PIXEL;
    w.in_red   = CH_W'($urandom);
    w.in_green = CH_W'($urandom);
    w.in_blue  = CH_W'($urandom);
    return w;
  endfunction

  function automatic in_word_t drain_word();
    in_word_t w;
    w = pixel_word();        // colour bits are don't-care on drain
    w.req_type = REQ_DRAIN;
    return w;
  endfunction

  // ---------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------
  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [DIM_W-1:0]     val;
    in_word_t             w;
    bit                   typed;
    out_word_t            exp_w;
  } stim_row_t;

  stim_row_t dir_tab [$];

  function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] v);
    dir_tab.push_back('{1'b1, idx, v, '0, 1'b0, '0});
  endfunction

  function automatic void add_word(logic rt, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                   bit typed = 0, out_word_t e = '0);
    dir_tab.push_back('{1'b0, CFG_FRAME_WIDTH, '0, '{rt, r, g, b}, typed, e});
  endfunction

  function automatic void build_directed();
    add_word(REQ_DRAIN, 8'h00, 8'h00, 8'h00);          // drain mid-frame: ignored
    add_word(REQ_PIXEL, 8'hff, 8'h00, 8'hff);          // 1024x1024 frame: no word yet
    add_cfg(CFG_FRAME_WIDTH,  11'd0);                  // zero clamps to 1
    add_cfg(CFG_FRAME_HEIGHT, 11'd0);
    // 1x1 frame: the blur is the pixel itself, marked last
    add_word(REQ_PIXEL, 8'hff, 8'hff, 8'hff);
    add_word(REQ_PIXEL, 8'h12, 8'h34, 8'h56);          // frame complete: ignored
    add_word(REQ_DRAIN, 8'hff, 8'hff, 8'hff, 1, '{8'hff, 8'hff, 8'hff, 1'b1});
    add_word(REQ_DRAIN, 8'h00, 8'h00, 8'h00);          // nothing pending: ignored
    add_word(REQ_PIXEL, 8'h00, 8'h00, 8'h00);
    add_word(REQ_DRAIN, 8'h00, 8'h00, 8'h00, 1, '{8'h00, 8'h00, 8'h00, 1'b1});
    add_cfg(CFG_FRAME_WIDTH,  11'h7ff);                // above max clamps to 1024
    add_cfg(CFG_FRAME_HEIGHT, 11'h7ff);
    add_cfg(CFG_FRAME_WIDTH,  11'd3);
    add_cfg(CFG_FRAME_HEIGHT, 11'd3);
    // 3x3 frame with extreme channel values, checked by the predictor
    for (int k = 0; k < 9; k++)
      add_word(REQ_PIXEL, (k % 2) ? 8'hff : 8'h00, (k % 3) ? 8'h01 : 8'hfe, 8'h80);
    add_word(REQ_PIXEL, 8'hff, 8'hff, 8'hff);          // after completion: ignored
    for (int k = 0; k < 4; k++) add_word(REQ_DRAIN, 8'h00, 8'h00, 8'h00);
  endfunction

  // words the frame leaves behind after its last pixel
  function automatic int drains_owed(int w, int h);
    int during;
    during = (h - 1) * (w - 1) + ((h >= 2) ? h - 2 : 0);
    return w * h - during;
  endfunction

  // ---------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------
  initial begin
    int w, h, owed, cut;
    int n_frames, n_aborted;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_valid  = 1'b0;
    cfg_index  = CFG_FRAME_WIDTH;
    cfg_data   = '0;
    row_typed  = 1'b0;
    row_expect = '0;
    no_idle    = 1'b0;
    n_fail = 0; n_blurred = 0; n_frames_done = 0; n_words = 0; n_drains = 0; n_cfg = 0;
    n_frames = 0; n_aborted = 0;
    fw = MAX_WIDTH; fh = MAX_HEIGHT;
    restart_counters();
    for (int k = 0; k < 9; k++) win[k] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    build_directed();
    foreach (dir_tab[k]) begin
      if (dir_tab[k].is_cfg) write_reg(dir_tab[k].idx, dir_tab[k].val);
      else                   send_word(dir_tab[k].w, dir_tab[k].typed, dir_tab[k].exp_w);
    end
    in_valid  <= 1'b0;
    row_typed <= 1'b0;
    @(posedge clk);

    // random frames: mostly small, a few wide, some cut short
    while (n_words < N_WORDS + dir_tab.size()) begin
      no_idle = ($urandom_range(9) == 0);
      if ($urandom_range(49) == 0) begin
        w = $urandom_range(MAX_WIDTH, 200); h = $urandom_range(2, 1);
      end else begin
        w = $urandom_range(12, 1); h = $urandom_range(8, 1);
      end
      // occasionally write out-of-range values that clamp to the same size
      if (w == 1 && $urandom_range(1)) write_reg(CFG_FRAME_WIDTH, 11'd0);
      else if (w == MAX_WIDTH && $urandom_range(1))
        write_reg(CFG_FRAME_WIDTH, DIM_W'($urandom_range(11'h7ff, MAX_WIDTH)));
      else write_reg(CFG_FRAME_WIDTH, DIM_W'(w));
      if (h == 1 && $urandom_range(1)) write_reg(CFG_FRAME_HEIGHT, 11'd0);
      else write_reg(CFG_FRAME_HEIGHT, DIM_W'(h));
      n_frames++;

      // a broken frame stops part-way; the next write restarts it
      cut = ($urandom_range(9) == 0) ? $urandom_range(w * h - 1) : -1;
      for (int p = 0; p < w * h && p != cut; p++) begin
        if ($urandom_range(19) == 0)
          send_word(drain_word(), 1'b0, '0);           // early drain: ignored
        send_word(pixel_word(), 1'b0, '0);
      end
      if (cut >= 0) begin
        n_aborted++;
        continue;
      end
      if ($urandom_range(7) == 0) send_word(pixel_word(), 1'b0, '0);  // ignored
      owed = drains_owed(w, h);
      for (int d = 0; d < owed; d++) send_word(drain_word(), 1'b0, '0);
      if ($urandom_range(7) == 0) send_word(drain_word(), 1'b0, '0);  // ignored
    end
    in_valid  <= 1'b0;
    row_typed <= 1'b0;

    while (blur_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("Covered %0d words (%0d drains), %0d register writes, %0d frames (%0d cut short).",
             n_words, n_drains, n_cfg, n_frames, n_aborted);
    $display("Checked %0d blurred pixels over %0d completed frames; %0d mismatches.",
             n_blurred, n_frames_done, n_fail);
    if (n_fail == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
